/* design/sac_pkg.sv */
// ----------------------------------------------------------------------------
// sac_pkg: shared types for the set-associative write-through cache
// Word types, controller commands and datapath status.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int ADDR_BITS  = 20;
    localparam int BEAT_BYTES = 8;
    localparam int MEM_ROW_W  = ADDR_BITS - 3;
    localparam int CMD_BEAT_W = 5;

    typedef struct packed {
        logic                 op;
        logic [ADDR_BITS-1:0] addr;
        logic [2:0]           len;
        logic [31:0]          write_data;
        logic [2:0]           victim_way;
    } t_sac_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        hit;
        logic [2:0]  way;
        logic        filled;
    } t_sac_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOOKUP1,
        OP_LOOKUP2,
        OP_WRITE0,
        OP_WRITE1,
        OP_READ0,
        OP_READ1,
        OP_FILL
    } t_sac_op;

    typedef struct packed {
        t_sac_op               op;
        logic                  accept;
        logic                  load_out;
        logic [CMD_BEAT_W-1:0] beat;
        logic [MEM_ROW_W-1:0]  clear_idx;
    } t_sac_cmd;

    typedef struct packed {
        logic is_write;
        logic beat_cross;
        logic line_cross;
        logic hit1;
    } t_sac_stat;

endpackage

/* design/set_assoc_write_through_cache.sv */
// Steps: tag lookup, then for a write one or two 8-byte row writes, for a read
//   one or two row reads; a miss adds a fill of the line, LINE_SIZE/8 rows.
// One word at a time: no new input word is taken until the last result is
//   loaded into the output register.
// Reset: a clearing pass over all 2^17 memory rows zeroes the backing memory and
//   the tag valid bits; no input word is taken until it ends.
// ----------------------------------------------------------------------------
// set_assoc_write_through_cache: set-associative write-through cache
// Cache with its own backing byte memory; the input picks the victim on a full set.
// ----------------------------------------------------------------------------
module set_assoc_write_through_cache #(
    parameter int NUM_SETS  = 128,
    parameter int NUM_WAYS  = 8,
    parameter int LINE_SIZE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sac_pkg::t_sac_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sac_pkg::t_sac_out o_out_word
);

    // Commands flow down, status flows back; nothing else joins the two halves
    sac_pkg::t_sac_cmd  cmd;
    sac_pkg::t_sac_stat stat;

    // Sequencer: clearing pass, then lookup, write-through, fill and read steps
    sac_ctrl #(
        .LINE_SIZE (LINE_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Datapath: tag rows, line data and backing memory, all 8 bytes wide where
    // data moves; the output word register parts the two channels
    sac_datapath #(
        .NUM_SETS  (NUM_SETS),
        .NUM_WAYS  (NUM_WAYS),
        .LINE_SIZE (LINE_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_stat     (stat),
        .o_out_word (o_out_word)
    );

endmodule

/* design/sac_datapath.sv */
// ----------------------------------------------------------------------------
// sac_datapath: tag, line and backing memories with access alignment
// Executes one controller command per cycle.
// ----------------------------------------------------------------------------
module sac_datapath #(
    parameter int NUM_SETS  = 128,
    parameter int NUM_WAYS  = 8,
    parameter int LINE_SIZE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sac_pkg::t_sac_cmd  i_cmd,
    input  sac_pkg::t_sac_in   i_in_word,
    output sac_pkg::t_sac_stat o_stat,
    output sac_pkg::t_sac_out  o_out_word
);

    localparam int AB      = sac_pkg::ADDR_BITS;
    localparam int RW      = sac_pkg::MEM_ROW_W;
    localparam int OFF_W   = $clog2(LINE_SIZE);
    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int TAG_W   = AB - OFF_W - SET_W;
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int BEAT_W  = OFF_W - 3;
    localparam int LADDR_W = SET_W + WAY_W + BEAT_W;

    typedef logic [NUM_WAYS-1:0][TAG_W:0] t_tag_row;

    logic [63:0] r_mem      [2**RW];
    logic [63:0] r_line_mem [2**LADDR_W];
    t_tag_row    r_tag_mem  [NUM_SETS];

    sac_pkg::t_sac_in  r_req;
    sac_pkg::t_sac_out r_out;
    sac_pkg::t_sac_op  r_prev_op;
    logic [63:0]       r_mem_q;
    logic [63:0]       r_line_q;
    t_tag_row          r_tag_q;
    t_tag_row          r_row1;
    logic              r_hit1;
    logic              r_hit2;
    logic [WAY_W-1:0]  r_way1;
    logic [WAY_W-1:0]  r_way2;
    logic [BEAT_W-1:0] r_fill_beat;
    logic [127:0]      r_win;

    logic [2:0]         len_e;
    logic [3:0]         lmask4;
    logic [AB-1:0]      a_last;
    logic [RW-1:0]      row0, row1;
    logic [SET_W-1:0]   set1, set2;
    logic [TAG_W-1:0]   tag1, tag2;
    logic [BEAT_W-1:0]  beat0, beat1;
    logic [127:0]       win_w;
    logic [15:0]        be16;
    logic               line_cross;
    logic [NUM_WAYS-1:0] m1, m2;
    logic [WAY_W-1:0]   mw1, mw2, inv_way, vic_way;
    logic               any_inv;
    logic [127:0]       win_sh;
    logic [31:0]        mask32;
    logic [31:0]        rd32;
    logic [63:0]        rd_src;

    logic               mem_we;
    logic [RW-1:0]      mem_waddr, mem_raddr;
    logic [63:0]        mem_wdata;
    logic [7:0]         mem_be;
    logic               line_we;
    logic [LADDR_W-1:0] line_waddr, line_raddr;
    logic [63:0]        line_wdata;
    logic [7:0]         line_be;
    logic               tag_we;
    logic [SET_W-1:0]   tag_waddr, tag_raddr;
    t_tag_row           tag_wdata;

    function automatic logic [WAY_W-1:0] f_victim(input logic [2:0] v);
        logic [4:0] x;
        x = {2'b00, v};
        for (int i = 0; i < 8; i++) begin
            if (x >= 5'(NUM_WAYS)) begin
                x = x - 5'(NUM_WAYS);
            end
        end
        return WAY_W'(x);
    endfunction

    // Access geometry
    always_comb begin
        if (r_req.len == 3'd0) begin
            len_e = 3'd1;
        end else if (r_req.len > 3'd4) begin
            len_e = 3'd4;
        end else begin
            len_e = r_req.len;
        end
        case (len_e)
            3'd1:    lmask4 = 4'b0001;
            3'd2:    lmask4 = 4'b0011;
            3'd3:    lmask4 = 4'b0111;
            default: lmask4 = 4'b1111;
        endcase
        a_last     = r_req.addr + AB'(len_e) - AB'(1);
        row0       = r_req.addr[AB-1:3];
        row1       = a_last[AB-1:3];
        set1       = r_req.addr[OFF_W +: SET_W];
        set2       = a_last[OFF_W +: SET_W];
        tag1       = r_req.addr[AB-1 -: TAG_W];
        tag2       = a_last[AB-1 -: TAG_W];
        beat0      = r_req.addr[OFF_W-1:3];
        beat1      = a_last[OFF_W-1:3];
        line_cross = (a_last[AB-1:OFF_W] != r_req.addr[AB-1:OFF_W]);
        win_w      = 128'(r_req.write_data) << {r_req.addr[2:0], 3'b000};
        be16       = 16'(lmask4) << r_req.addr[2:0];
        for (int b = 0; b < 4; b++) begin
            mask32[b*8 +: 8] = {8{lmask4[b]}};
        end
        win_sh = r_win >> {r_req.addr[2:0], 3'b000};
        rd32   = win_sh[31:0] & mask32;
    end

    // Way compare on the registered tag row
    always_comb begin
        mw1     = '0;
        mw2     = '0;
        inv_way = '0;
        any_inv = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            m1[w] = r_tag_q[w][TAG_W] && (r_tag_q[w][TAG_W-1:0] == tag1);
            m2[w] = r_tag_q[w][TAG_W] && (r_tag_q[w][TAG_W-1:0] == tag2);
            if (m1[w]) begin
                mw1 = WAY_W'(w);
            end
            if (m2[w]) begin
                mw2 = WAY_W'(w);
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!r_tag_q[w][TAG_W]) begin
                inv_way = WAY_W'(w);
                any_inv = 1'b1;
            end
        end
        vic_way = any_inv ? inv_way : f_victim(r_req.victim_way);
    end

    // Memory port steering
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = row0;
        mem_wdata  = win_w[63:0];
        mem_be     = be16[7:0];
        mem_raddr  = row0;
        line_we    = 1'b0;
        line_waddr = {set1, r_way1, beat0};
        line_wdata = win_w[63:0];
        line_be    = be16[7:0];
        line_raddr = {set1, r_way1, beat0};
        tag_we     = 1'b0;
        tag_waddr  = set1;
        tag_wdata  = r_row1;
        tag_raddr  = set1;
        tag_wdata[r_way1] = {1'b1, tag1};
        rd_src     = (r_hit1 && !line_cross) ? r_line_q : r_mem_q;
        case (i_cmd.op)
            sac_pkg::OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = i_cmd.clear_idx;
                mem_wdata = '0;
                mem_be    = '1;
                tag_we    = (i_cmd.clear_idx < RW'(NUM_SETS));
                tag_waddr = i_cmd.clear_idx[SET_W-1:0];
                tag_wdata = '0;
            end
            sac_pkg::OP_LOOKUP2: begin
                tag_raddr = set2;
            end
            sac_pkg::OP_WRITE0: begin
                mem_we  = 1'b1;
                line_we = r_hit1;
            end
            sac_pkg::OP_WRITE1: begin
                mem_we     = 1'b1;
                mem_waddr  = row1;
                mem_wdata  = win_w[127:64];
                mem_be     = be16[15:8];
                line_wdata = win_w[127:64];
                line_be    = be16[15:8];
                if (line_cross) begin
                    line_we    = r_hit2;
                    line_waddr = {set2, r_way2, beat1};
                end else begin
                    line_we    = r_hit1;
                    line_waddr = {set1, r_way1, beat1};
                end
            end
            sac_pkg::OP_READ1: begin
                mem_raddr  = row1;
                line_raddr = {set1, r_way1, beat1};
            end
            sac_pkg::OP_FILL: begin
                mem_raddr = {r_req.addr[AB-1:OFF_W], i_cmd.beat[BEAT_W-1:0]};
                tag_we    = (i_cmd.beat == '0);
            end
            default: begin
            end
        endcase
        // Write the previous fill beat into the line once its memory read lands
        if (r_prev_op == sac_pkg::OP_FILL) begin
            line_we    = 1'b1;
            line_waddr = {set1, r_way1, r_fill_beat};
            line_wdata = r_mem_q;
            line_be    = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int b = 0; b < 8; b++) begin
                if (mem_be[b]) begin
                    r_mem[mem_waddr][b*8 +: 8] <= mem_wdata[b*8 +: 8];
                end
            end
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (line_we) begin
            for (int b = 0; b < 8; b++) begin
                if (line_be[b]) begin
                    r_line_mem[line_waddr][b*8 +: 8] <= line_wdata[b*8 +: 8];
                end
            end
        end
        r_line_q <= r_line_mem[line_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tag_mem[tag_waddr] <= tag_wdata;
        end
        r_tag_q <= r_tag_mem[tag_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_op <= sac_pkg::OP_NONE;
        end else begin
            r_prev_op <= i_cmd.op;
        end
        if (i_cmd.accept) begin
            r_req <= i_in_word;
        end
        if (i_cmd.op == sac_pkg::OP_FILL) begin
            r_fill_beat <= i_cmd.beat[BEAT_W-1:0];
        end
        case (r_prev_op)
            sac_pkg::OP_LOOKUP1: begin
                r_row1 <= r_tag_q;
                r_hit1 <= |m1;
                r_way1 <= (|m1) ? mw1 : vic_way;
            end
            sac_pkg::OP_LOOKUP2: begin
                r_hit2 <= |m2;
                r_way2 <= mw2;
            end
            sac_pkg::OP_READ0: begin
                r_win[63:0] <= rd_src;
            end
            sac_pkg::OP_READ1: begin
                r_win[127:64] <= rd_src;
            end
            default: begin
            end
        endcase
        if (i_cmd.load_out) begin
            r_out.read_data <= r_req.op ? 32'd0 : rd32;
            r_out.hit       <= r_hit1;
            r_out.way       <= 3'(r_way1);
            r_out.filled    <= !r_hit1;
        end
    end

    assign o_stat.is_write   = r_req.op;
    assign o_stat.beat_cross = (row1 != row0);
    assign o_stat.line_cross = line_cross;
    assign o_stat.hit1       = r_hit1;
    assign o_out_word        = r_out;

endmodule

/* design/sac_ctrl.sv */
// ----------------------------------------------------------------------------
// sac_ctrl: access sequencer for the write-through cache
// Clears memory after reset, then steps lookup, write, fill and read.
// ----------------------------------------------------------------------------
module sac_ctrl #(
    parameter int LINE_SIZE = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  sac_pkg::t_sac_stat i_stat,
    output sac_pkg::t_sac_cmd  o_cmd
);

    localparam int ROWS   = LINE_SIZE / sac_pkg::BEAT_BYTES;
    localparam int BEAT_W = $clog2(ROWS);
    localparam int RW     = sac_pkg::MEM_ROW_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK1, S_LOOK2, S_BRANCH, S_WR0, S_WR1,
        S_FILL, S_FILLW, S_RD0, S_RD1, S_RDW, S_DONE
    } t_state;

    t_state            r_state;
    logic [RW-1:0]     r_clr;
    logic [BEAT_W-1:0] r_beat;
    logic              r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = sac_pkg::OP_NONE;
        o_cmd.clear_idx = r_clr;
        o_cmd.beat      = sac_pkg::CMD_BEAT_W'(r_beat);
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        unique case (r_state)
            S_CLEAR: o_cmd.op = sac_pkg::OP_CLEAR;
            S_LOOK1: o_cmd.op = sac_pkg::OP_LOOKUP1;
            S_LOOK2: o_cmd.op = (i_stat.is_write && i_stat.line_cross) ?
                                sac_pkg::OP_LOOKUP2 : sac_pkg::OP_NONE;
            S_WR0:   o_cmd.op = sac_pkg::OP_WRITE0;
            S_WR1:   o_cmd.op = sac_pkg::OP_WRITE1;
            S_FILL:  o_cmd.op = sac_pkg::OP_FILL;
            S_RD0:   o_cmd.op = sac_pkg::OP_READ0;
            S_RD1:   o_cmd.op = sac_pkg::OP_READ1;
            default: o_cmd.op = sac_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + RW'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_LOOK1;
                    end
                end
                S_LOOK1: r_state <= S_LOOK2;
                S_LOOK2: r_state <= S_BRANCH;
                S_BRANCH: begin
                    r_beat <= '0;
                    if (i_stat.is_write) begin
                        r_state <= S_WR0;
                    end else if (!i_stat.hit1) begin
                        r_state <= S_FILL;
                    end else begin
                        r_state <= S_RD0;
                    end
                end
                S_WR0: begin
                    if (i_stat.beat_cross) begin
                        r_state <= S_WR1;
                    end else begin
                        r_state <= i_stat.hit1 ? S_DONE : S_FILL;
                    end
                end
                S_WR1: r_state <= i_stat.hit1 ? S_DONE : S_FILL;
                S_FILL: begin
                    r_beat <= r_beat + BEAT_W'(1);
                    if (r_beat == BEAT_W'(ROWS - 1)) begin
                        r_state <= S_FILLW;
                    end
                end
                S_FILLW: r_state <= i_stat.is_write ? S_DONE : S_RD0;
                S_RD0:   r_state <= i_stat.beat_cross ? S_RD1 : S_RDW;
                S_RD1:   r_state <= S_RDW;
                S_RDW:   r_state <= S_DONE;
                S_DONE: begin
                    if (o_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* design/sac_checker.sv */
// ----------------------------------------------------------------------------
// sac_checker: port-level checks for the write-through cache
// Result consistency and one-word-at-a-time acceptance.
// ----------------------------------------------------------------------------
module sac_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input sac_pkg::t_sac_out o_out_word
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_miss_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.hit |-> o_out_word.filled)
        else $error("miss without a fill");

    a_hit_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.hit |-> !o_out_word.filled)
        else $error("hit reported a fill");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken during an access");

endmodule

bind set_assoc_write_through_cache sac_checker u_sac_checker (.*);
